// ===== hw/rtl/vsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_pkg: shared types and constants of the valve stem friction simulator
// Item structs, register indexes, multiplier request/response groups and
// the default model parameters.
// ----------------------------------------------------------------------------
package vsf_pkg;

    localparam int unsigned VSF_SUBSTEPS    = 16;
    localparam int unsigned VSF_HALF_DT     = 8192;
    localparam logic [46:0] VSF_INV_MASS    = 47'd16777216;
    localparam logic signed [47:0] VSF_POS_MIN = 48'sd0;
    localparam logic signed [47:0] VSF_POS_MAX = 48'sd16777216;
    localparam int unsigned VSF_TABLE_DEPTH = 256;

    localparam logic signed [47:0] VSF_QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VSF_QMIN = 48'sh8000_0000_0000;

    // exp(-1/16) * 2^32, step factor of the Stribeck table
    localparam logic [31:0] VSF_EXP_R = 32'd4034748382;

    localparam logic [2:0] REG_SPRING_STIFFNESS = 3'd0;
    localparam logic [2:0] REG_DIAPHRAGM_AREA   = 3'd1;
    localparam logic [2:0] REG_SPRING_PRELOAD   = 3'd2;
    localparam logic [2:0] REG_COULOMB_FORCE    = 3'd3;
    localparam logic [2:0] REG_STATIC_FORCE     = 3'd4;
    localparam logic [2:0] REG_VISCOUS_COEFF    = 3'd5;
    localparam logic [2:0] REG_STRIBECK_VINV    = 3'd6;
    localparam logic [2:0] REG_INITIAL_POSITION = 3'd7;

    typedef struct packed {
        logic signed [47:0] pressure_sample;
        logic               last_sample;
    } vsf_in_t;

    typedef struct packed {
        logic [31:0]        sample_number;
        logic signed [47:0] pressure_value;
        logic signed [47:0] stem_position;
        logic signed [47:0] stem_velocity;
        logic signed [47:0] stem_acceleration;
        logic signed [47:0] friction_force;
        logic               final_result;
    } vsf_out_t;

    typedef struct packed {
        logic               start;
        logic               sh23;
        logic signed [48:0] a;
        logic signed [48:0] b;
    } vsf_mul_req_t;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic signed [47:0] res;
    } vsf_mul_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/valve_stem_friction_sim.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// valve_stem_friction_sim: pneumatic valve stem with stick-slip friction
// Q24.24 stem model driven by a stream of diaphragm pressure samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item) takes pressure samples; the
// output channel (out_valid/out_stall/out_item) gives the stem state at the
// held sample, plus a closing result after a sample marked last.
// A sample arriving while another is held passes from S_IDLE to S_EMIT, which
// loads the result of the held sample into the output register once that is
// free; the sample then runs SUBSTEPS substeps on one shared multiplier. The
// multiplier chain of each substep sets the time per item, which is longer
// while the stem slips than while it sticks. The first sample of a sequence
// is only held, and gives a result only if it is marked last.
// A two-entry input queue accepts samples while the core works.
// After reset the Stribeck table fills with in_stall high; the user must make
// configuration writes only while idle, as the block does not enforce it.
// When out_stall is high the result waits in the output register and the
// core holds before its next result.
// ----------------------------------------------------------------------------
module valve_stem_friction_sim #(
    parameter int unsigned        SUBSTEPS    = vsf_pkg::VSF_SUBSTEPS,
    parameter int unsigned        HALF_DT     = vsf_pkg::VSF_HALF_DT,
    parameter logic [46:0]        INV_MASS    = vsf_pkg::VSF_INV_MASS,
    parameter logic signed [47:0] POS_MIN     = vsf_pkg::VSF_POS_MIN,
    parameter logic signed [47:0] POS_MAX     = vsf_pkg::VSF_POS_MAX,
    parameter int unsigned        TABLE_DEPTH = vsf_pkg::VSF_TABLE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  vsf_pkg::vsf_in_t  in_item,
    output logic              out_valid,
    input  wire logic         out_stall,
    output vsf_pkg::vsf_out_t out_item,
    input  wire logic         cfg_write,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);
    import vsf_pkg::*;

    localparam int unsigned TW = $clog2(TABLE_DEPTH);

    logic          q_valid;
    vsf_in_t       q_item;
    logic          q_pop;
    vsf_mul_req_t  mul_req;
    vsf_mul_rsp_t  mul_rsp;
    logic          tbl_ready;
    logic          tbl_rd;
    logic [TW-1:0] tbl_addr;
    logic          tbl_last;
    logic [23:0]   tbl_hi;
    logic [23:0]   tbl_nx;

    vsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (tbl_ready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    vsf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    vsf_stribeck #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TW          (TW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (tbl_ready),
        .rd      (tbl_rd),
        .rd_addr (tbl_addr),
        .rd_last (tbl_last),
        .hi      (tbl_hi),
        .nx      (tbl_nx)
    );

    vsf_core #(
        .SUBSTEPS    (SUBSTEPS),
        .HALF_DT     (HALF_DT),
        .INV_MASS    (INV_MASS),
        .POS_MIN     (POS_MIN),
        .POS_MAX     (POS_MAX),
        .TABLE_DEPTH (TABLE_DEPTH),
        .TW          (TW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .tbl_ready (tbl_ready),
        .tbl_rd    (tbl_rd),
        .tbl_addr  (tbl_addr),
        .tbl_last  (tbl_last),
        .tbl_hi    (tbl_hi),
        .tbl_nx    (tbl_nx)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/vsf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_front: input side
// Accepts pressure items and holds them in a two-entry queue for the core.
// ----------------------------------------------------------------------------
module vsf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             enable,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  vsf_pkg::vsf_in_t      in_item,
    output logic                  q_valid,
    output vsf_pkg::vsf_in_t      q_item,
    input  wire logic             q_pop
);
    import vsf_pkg::*;

    vsf_in_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign in_stall = (count_reg == 2'd2) || !enable;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vsf_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_mul: shared fixed-point multiplier
// Signed 48x48 product from four 24x24 partial products, rounded half away
// from zero, shifted by 24 or 23 and saturated to 48 bits.
// ----------------------------------------------------------------------------
module vsf_mul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  vsf_pkg::vsf_mul_req_t req,
    output vsf_pkg::vsf_mul_rsp_t rsp
);
    import vsf_pkg::*;

    localparam logic [2:0] STEP_FINISH = 3'd5;

    logic [47:0]        ma_reg;
    logic [47:0]        mb_reg;
    logic               neg_reg;
    logic               sh23_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [2:0]         step_reg;
    logic [47:0]        pp_reg;
    logic [95:0]        acc_reg;
    logic signed [47:0] res_reg;

    logic [48:0]        abs_a;
    logic [48:0]        abs_b;
    logic [23:0]        pa;
    logic [23:0]        pb;
    logic [95:0]        pp_sh;
    logic [96:0]        rnd;
    logic [73:0]        q;
    logic signed [47:0] fin;

    always_comb
    begin
        abs_a = req.a[48] ? 49'(-req.a) : 49'(req.a);
        abs_b = req.b[48] ? 49'(-req.b) : 49'(req.b);
        case (step_reg)
            3'd0:    begin pa = ma_reg[23:0];  pb = mb_reg[23:0];  end
            3'd1:    begin pa = ma_reg[23:0];  pb = mb_reg[47:24]; end
            3'd2:    begin pa = ma_reg[47:24]; pb = mb_reg[23:0];  end
            3'd3:    begin pa = ma_reg[47:24]; pb = mb_reg[47:24]; end
            default: begin pa = 24'd0;         pb = 24'd0;         end
        endcase
        // pp_reg holds the pair issued one step earlier
        case (step_reg)
            3'd1:    pp_sh = 96'(pp_reg);
            3'd2:    pp_sh = 96'(pp_reg) << 24;
            3'd3:    pp_sh = 96'(pp_reg) << 24;
            3'd4:    pp_sh = 96'(pp_reg) << 48;
            default: pp_sh = 96'd0;
        endcase
        rnd = {1'b0, acc_reg} + (sh23_reg ? (97'd1 << 22) : (97'd1 << 23));
        q   = sh23_reg ? rnd[96:23] : 74'(rnd[96:24]);
        if (neg_reg)
        begin
            fin = (q > 74'(49'h0_8000_0000_0000)) ? VSF_QMIN : 48'(-q[47:0]);
        end
        else
        begin
            fin = (q > 74'(VSF_QMAX)) ? VSF_QMAX : q[47:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.res  = res_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg   <= abs_a[47:0];
            mb_reg   <= abs_b[47:0];
            neg_reg  <= req.a[48] ^ req.b[48];
            sh23_reg <= req.sh23;
        end
        if (busy_reg && step_reg <= 3'd3)
        begin
            pp_reg <= pa * pb;
        end
        if (req.start)
        begin
            acc_reg <= 96'd0;
        end
        else if (busy_reg && step_reg != 3'd0 && step_reg != STEP_FINISH)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
        if (busy_reg && step_reg == STEP_FINISH)
        begin
            res_reg <= fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_FINISH)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg && !done_reg)
        else $error("multiplier started while busy");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/vsf_stribeck.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_stribeck: Stribeck exponential table
// Fills itself after reset from the exp(-1/16) recurrence, one entry a
// cycle, then serves an entry and its successor (zero after the last entry) per read.
// ----------------------------------------------------------------------------
module vsf_stribeck #(
    parameter int unsigned TABLE_DEPTH = vsf_pkg::VSF_TABLE_DEPTH,
    parameter int unsigned TW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               ready,
    input  wire logic          rd,
    input  wire logic [TW-1:0] rd_addr,
    input  wire logic          rd_last,
    output logic [23:0]        hi,
    output logic [23:0]        nx
);
    import vsf_pkg::*;

    logic [23:0]   mem [TABLE_DEPTH];
    logic [TW:0]   fill_cnt_reg;
    logic [23:0]   e_reg;
    logic          ready_reg;
    logic [23:0]   hi_reg;
    logic [23:0]   nx_raw_reg;
    logic          last_reg;
    logic [55:0]   prod;
    logic [56:0]   prod_rnd;
    logic [TW-1:0] nx_addr;

    assign prod     = e_reg * VSF_EXP_R;
    assign prod_rnd = {1'b0, prod} + (57'd1 << 31);
    assign nx_addr  = rd_last ? '0 : rd_addr + TW'(1);
    assign ready    = ready_reg;
    assign hi       = hi_reg;
    assign nx       = last_reg ? 24'd0 : nx_raw_reg;

    always_ff @(posedge clk)
    begin
        if (!ready_reg)
        begin
            mem[fill_cnt_reg[TW-1:0]] <= e_reg;
        end
        if (rd)
        begin
            hi_reg     <= mem[rd_addr];
            nx_raw_reg <= mem[nx_addr];
            last_reg   <= rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            e_reg        <= 24'h80_0000;
            ready_reg    <= 1'b0;
        end
        else if (!ready_reg)
        begin
            e_reg        <= prod_rnd[55:32];
            fill_cnt_reg <= fill_cnt_reg + (TW+1)'(1);
            if (fill_cnt_reg == (TW+1)'(TABLE_DEPTH - 1))
            begin
                ready_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vsf_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_core: integration back end
// Takes queued samples, emits results and runs the trapezoidal substeps of
// the stick-slip stem model through the shared multiplier.
// ----------------------------------------------------------------------------
module vsf_core #(
    parameter int unsigned        SUBSTEPS    = vsf_pkg::VSF_SUBSTEPS,
    parameter int unsigned        HALF_DT     = vsf_pkg::VSF_HALF_DT,
    parameter logic [46:0]        INV_MASS    = vsf_pkg::VSF_INV_MASS,
    parameter logic signed [47:0] POS_MIN     = vsf_pkg::VSF_POS_MIN,
    parameter logic signed [47:0] POS_MAX     = vsf_pkg::VSF_POS_MAX,
    parameter int unsigned        TABLE_DEPTH = vsf_pkg::VSF_TABLE_DEPTH,
    parameter int unsigned        TW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [47:0]      cfg_data,
    input  wire logic             q_valid,
    input  vsf_pkg::vsf_in_t      q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output vsf_pkg::vsf_out_t     out_item,
    output vsf_pkg::vsf_mul_req_t mul_req,
    input  vsf_pkg::vsf_mul_rsp_t mul_rsp,
    input  wire logic             tbl_ready,
    output logic                  tbl_rd,
    output logic [TW-1:0]         tbl_addr,
    output logic                  tbl_last,
    input  wire logic [23:0]      tbl_hi,
    input  wire logic [23:0]      tbl_nx
);
    import vsf_pkg::*;

    localparam int unsigned CW    = $clog2(SUBSTEPS + 1);
    localparam int unsigned RW    = $clog2(SUBSTEPS) + 2;
    localparam logic [CW-1:0] SUB_LAST = CW'(SUBSTEPS - 1);
    localparam logic [RW-1:0] SUB_DIV  = RW'(SUBSTEPS);

    // reciprocal of SUBSTEPS, exact for every partial dividend below 2^XW
    localparam int unsigned XW     = RW + 16;
    localparam int unsigned DIV_SH = XW + $clog2(SUBSTEPS);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SH) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS);
    localparam logic [XW:0] RECIP = RECIP_FULL[XW:0];

    localparam logic [4:0] S_FILL    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_EMIT    = 5'd2;
    localparam logic [4:0] S_DIV     = 5'd3;
    localparam logic [4:0] S_SS      = 5'd4;
    localparam logic [4:0] S_M_AREA  = 5'd5;
    localparam logic [4:0] S_M_K     = 5'd6;
    localparam logic [4:0] S_M_U     = 5'd7;
    localparam logic [4:0] S_M_S     = 5'd8;
    localparam logic [4:0] S_TAB     = 5'd9;
    localparam logic [4:0] S_TAB_W   = 5'd10;
    localparam logic [4:0] S_INTERP  = 5'd11;
    localparam logic [4:0] S_M_LVL   = 5'd12;
    localparam logic [4:0] S_M_VISC  = 5'd13;
    localparam logic [4:0] S_M_ACC   = 5'd14;
    localparam logic [4:0] S_M_V     = 5'd15;
    localparam logic [4:0] S_M_X     = 5'd16;
    localparam logic [4:0] S_COMMIT  = 5'd17;
    localparam logic [4:0] S_FINAL   = 5'd18;

    function automatic logic signed [48:0] ext(input logic signed [47:0] v);
        return {v[47], v};
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47])
        begin
            r = v[48] ? VSF_QMIN : VSF_QMAX;
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

    // configuration
    logic [46:0]        k_reg, area_reg, fc_reg, fs_reg, visc_reg, vinv_reg;
    logic signed [47:0] preload_reg, init_pos_reg;

    // sequence state
    logic [4:0]         state_reg;
    logic signed [47:0] held_reg;
    logic               held_flag_reg;
    logic signed [47:0] x_reg, v_reg, vb_reg, acc_reg, f_reg, dp_reg;
    logic               stuck_reg;
    logic [31:0]        count_reg;

    // item and substep working registers
    logic signed [47:0] p_reg;
    logic               last_reg;
    logic               dneg_reg;
    logic [47:0]        dvd_reg;
    logic [RW-1:0]      rem_reg;
    logic [1:0]         div_cnt_reg;
    logic [47:0]        qacc_reg;
    logic [RW-1:0]      racc_reg;
    logic [CW-1:0]      sub_reg;
    logic               issued_reg;
    logic signed [47:0] vp_reg, t1_reg, net_reg, u_reg, s_reg, fat_reg;
    logic signed [47:0] anew_reg, vnew_reg, xnew_reg;
    logic               in_range_reg;
    logic [19:0]        frac_reg;
    logic [43:0]        dprod_reg;
    logic [23:0]        e_reg;

    logic               out_valid_reg;
    vsf_out_t           out_item_reg;

    // combinational helpers
    logic               can_load;
    logic               out_load;
    logic               m_state;
    logic               m_done;
    logic               stuck_n;
    logic signed [47:0] net_c;
    logic signed [48:0] mag_c, lim_c;
    logic signed [47:0] fat_stuck;
    logic signed [47:0] lvl_c, fat_lvl, fat_visc, v_c, x_c;
    logic signed [48:0] abs_vp;
    logic signed [48:0] diff_c;
    logic [XW-1:0]      div_x;
    logic [2*XW:0]      div_prod;
    logic [15:0]        div_q;
    logic [XW-1:0]      div_qn;
    logic [XW-1:0]      div_r;
    logic [RW-1:0]      rsum;
    logic signed [48:0] p_now49;
    logic               vp_pos;

    assign can_load  = !out_valid_reg || !out_stall;
    assign out_load  = ((state_reg == S_EMIT) || (state_reg == S_FINAL)) && can_load;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign m_state   = (state_reg == S_M_AREA) || (state_reg == S_M_K) ||
                       (state_reg == S_M_U) || (state_reg == S_M_S) ||
                       (state_reg == S_M_LVL) || (state_reg == S_M_VISC) ||
                       (state_reg == S_M_ACC) || (state_reg == S_M_V) ||
                       (state_reg == S_M_X);
    assign m_done    = issued_reg && mul_rsp.done;
    assign tbl_rd    = (state_reg == S_TAB);
    assign tbl_addr  = s_reg[20 +: TW];
    assign tbl_last  = (s_reg[20 +: TW] == TW'(TABLE_DEPTH - 1));

    always_comb
    begin
        vp_pos = !vp_reg[47] && (vp_reg != 48'sd0);
        if (vb_reg == 48'sd0 && !stuck_reg)
        begin
            stuck_n = 1'b0;
        end
        else
        begin
            stuck_n = (vb_reg == 48'sd0) || (v_reg == 48'sd0) || (vb_reg[47] != v_reg[47]);
        end
        net_c     = sat48(ext(sat48(ext(t1_reg) - ext(mul_rsp.res))) - ext(preload_reg));
        mag_c     = net_c[47] ? -ext(net_c) : ext(net_c);
        lim_c     = (mag_c < $signed({2'b00, fs_reg})) ? mag_c : $signed({2'b00, fs_reg});
        fat_stuck = net_c[47] ? 48'(-lim_c) : ((net_c != 48'sd0) ? lim_c[47:0] : 48'sd0);
        lvl_c     = sat48($signed({2'b00, fc_reg}) + ext(mul_rsp.res));
        fat_lvl   = vp_pos ? lvl_c : (vp_reg[47] ? sat48(-ext(lvl_c)) : 48'sd0);
        fat_visc  = sat48(ext(fat_reg) + ext(mul_rsp.res));
        v_c       = sat48(ext(mul_rsp.res) + ext(vp_reg));
        x_c       = sat48(ext(mul_rsp.res) + ext(x_reg));
        abs_vp    = vp_reg[47] ? -ext(vp_reg) : ext(vp_reg);
        diff_c    = ext(p_reg) - ext(held_reg);
        div_x     = {rem_reg, dvd_reg[47:32]};
        div_prod  = (2*XW+1)'(div_x) * (2*XW+1)'(RECIP);
        div_q     = div_prod[DIV_SH +: 16];
        div_qn    = XW'(div_q) * XW'(SUBSTEPS);
        div_r     = div_x - div_qn;
        rsum      = racc_reg + rem_reg;
        p_now49   = ext(held_reg) + (dneg_reg ? -$signed({1'b0, qacc_reg})
                                              : $signed({1'b0, qacc_reg}));

        mul_req.start = m_state && !issued_reg;
        mul_req.sh23  = (state_reg == S_M_LVL);
        case (state_reg)
            S_M_AREA: begin mul_req.a = $signed({2'b00, area_reg}); mul_req.b = ext(dp_reg); end
            S_M_K:    begin mul_req.a = $signed({2'b00, k_reg});    mul_req.b = ext(x_reg);  end
            S_M_U:    begin mul_req.a = abs_vp; mul_req.b = $signed({2'b00, vinv_reg}); end
            S_M_S:    begin mul_req.a = ext(u_reg); mul_req.b = ext(u_reg); end
            S_M_LVL:
            begin
                mul_req.a = $signed({2'b00, fs_reg}) - $signed({2'b00, fc_reg});
                mul_req.b = $signed({25'd0, e_reg});
            end
            S_M_VISC: begin mul_req.a = $signed({2'b00, visc_reg}); mul_req.b = ext(vp_reg); end
            S_M_ACC:
            begin
                mul_req.a = ext(sat48(ext(net_reg) - ext(fat_reg)));
                mul_req.b = $signed({2'b00, INV_MASS});
            end
            S_M_V:
            begin
                mul_req.a = $signed(49'(HALF_DT));
                mul_req.b = ext(sat48(ext(anew_reg) + ext(acc_reg)));
            end
            S_M_X:
            begin
                mul_req.a = $signed(49'(HALF_DT));
                mul_req.b = ext(sat48(ext(vnew_reg) + ext(vp_reg)));
            end
            default:  begin mul_req.a = 49'sd0; mul_req.b = 49'sd0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            area_reg      <= '0;
            preload_reg   <= '0;
            fc_reg        <= '0;
            fs_reg        <= '0;
            visc_reg      <= '0;
            vinv_reg      <= 47'd16777216;
            init_pos_reg  <= '0;
            state_reg     <= S_FILL;
            held_reg      <= '0;
            held_flag_reg <= 1'b0;
            x_reg         <= '0;
            v_reg         <= '0;
            vb_reg        <= '0;
            acc_reg       <= '0;
            f_reg         <= '0;
            dp_reg        <= '0;
            stuck_reg     <= 1'b1;
            count_reg     <= '0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
            racc_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SPRING_STIFFNESS: k_reg        <= cfg_data[46:0];
                    REG_DIAPHRAGM_AREA:   area_reg     <= cfg_data[46:0];
                    REG_SPRING_PRELOAD:   preload_reg  <= cfg_data;
                    REG_COULOMB_FORCE:    fc_reg       <= cfg_data[46:0];
                    REG_STATIC_FORCE:     fs_reg       <= cfg_data[46:0];
                    REG_VISCOUS_COEFF:    visc_reg     <= cfg_data[46:0];
                    REG_STRIBECK_VINV:    vinv_reg     <= cfg_data[46:0];
                    REG_INITIAL_POSITION: init_pos_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (m_state && !issued_reg)
            begin
                issued_reg <= 1'b1;
            end
            else if (m_done)
            begin
                issued_reg <= 1'b0;
            end

            case (state_reg)
                S_FILL:
                begin
                    if (tbl_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        p_reg    <= q_item.pressure_sample;
                        last_reg <= q_item.last_sample;
                        if (held_flag_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            held_reg      <= q_item.pressure_sample;
                            held_flag_reg <= 1'b1;
                            if (q_item.last_sample)
                            begin
                                state_reg <= S_FINAL;
                            end
                        end
                    end
                end
                S_EMIT:
                begin
                    if (can_load)
                    begin
                        out_item_reg  <= '{count_reg, held_reg, x_reg, v_reg,
                                           acc_reg, f_reg, 1'b0};
                        dneg_reg      <= diff_c[48];
                        dvd_reg       <= diff_c[48] ? 48'(-diff_c) : diff_c[47:0];
                        rem_reg       <= '0;
                        div_cnt_reg   <= '0;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // one 16-bit quotient digit of |new - held| / SUBSTEPS a cycle
                    rem_reg     <= div_r[RW-1:0];
                    dvd_reg     <= {dvd_reg[31:0], div_q};
                    div_cnt_reg <= div_cnt_reg + 2'd1;
                    if (div_cnt_reg == 2'd2)
                    begin
                        qacc_reg  <= '0;
                        racc_reg  <= '0;
                        sub_reg   <= '0;
                        state_reg <= S_SS;
                    end
                end
                S_SS:
                begin
                    stuck_reg <= stuck_n;
                    vp_reg    <= v_reg;
                    state_reg <= S_M_AREA;
                end
                S_M_AREA:
                begin
                    if (m_done)
                    begin
                        t1_reg    <= mul_rsp.res;
                        state_reg <= S_M_K;
                    end
                end
                S_M_K:
                begin
                    if (m_done)
                    begin
                        net_reg <= net_c;
                        if (stuck_reg)
                        begin
                            fat_reg <= fat_stuck;
                            vp_reg  <= '0;
                            if (lim_c >= $signed({2'b00, fs_reg}))
                            begin
                                stuck_reg <= 1'b0;
                            end
                            state_reg <= S_M_ACC;
                        end
                        else
                        begin
                            state_reg <= S_M_U;
                        end
                    end
                end
                S_M_U:
                begin
                    if (m_done)
                    begin
                        u_reg     <= mul_rsp.res;
                        state_reg <= S_M_S;
                    end
                end
                S_M_S:
                begin
                    if (m_done)
                    begin
                        s_reg     <= mul_rsp.res;
                        state_reg <= S_TAB;
                    end
                end
                S_TAB:
                begin
                    in_range_reg <= (s_reg[47:20] < 28'(TABLE_DEPTH));
                    frac_reg     <= s_reg[19:0];
                    state_reg    <= S_TAB_W;
                end
                S_TAB_W:
                begin
                    dprod_reg <= (tbl_hi - tbl_nx) * frac_reg;
                    state_reg <= S_INTERP;
                end
                S_INTERP:
                begin
                    e_reg     <= in_range_reg ? tbl_hi - dprod_reg[43:20] : 24'd0;
                    state_reg <= S_M_LVL;
                end
                S_M_LVL:
                begin
                    if (m_done)
                    begin
                        fat_reg   <= fat_lvl;
                        state_reg <= S_M_VISC;
                    end
                end
                S_M_VISC:
                begin
                    if (m_done)
                    begin
                        fat_reg   <= fat_visc;
                        state_reg <= S_M_ACC;
                    end
                end
                S_M_ACC:
                begin
                    if (m_done)
                    begin
                        anew_reg  <= mul_rsp.res;
                        state_reg <= S_M_V;
                    end
                end
                S_M_V:
                begin
                    if (m_done)
                    begin
                        vnew_reg  <= v_c;
                        state_reg <= S_M_X;
                    end
                end
                S_M_X:
                begin
                    if (m_done)
                    begin
                        xnew_reg  <= x_c;
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    // clamp to the travel limits, then advance the interpolation
                    if (xnew_reg < POS_MIN)
                    begin
                        x_reg     <= POS_MIN;
                        acc_reg   <= '0;
                        v_reg     <= '0;
                        stuck_reg <= 1'b1;
                    end
                    else if (xnew_reg > POS_MAX)
                    begin
                        x_reg     <= POS_MAX;
                        acc_reg   <= '0;
                        v_reg     <= '0;
                        stuck_reg <= 1'b1;
                    end
                    else
                    begin
                        x_reg   <= xnew_reg;
                        acc_reg <= anew_reg;
                        v_reg   <= vnew_reg;
                    end
                    vb_reg <= vp_reg;
                    f_reg  <= fat_reg;
                    dp_reg <= p_now49[47:0];
                    if (rsum >= SUB_DIV)
                    begin
                        racc_reg <= rsum - SUB_DIV;
                        qacc_reg <= qacc_reg + dvd_reg + 48'd1;
                    end
                    else
                    begin
                        racc_reg <= rsum;
                        qacc_reg <= qacc_reg + dvd_reg;
                    end
                    if (sub_reg == SUB_LAST)
                    begin
                        sub_reg   <= '0;
                        count_reg <= count_reg + 32'd1;
                        held_reg  <= p_reg;
                        state_reg <= last_reg ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        sub_reg   <= sub_reg + CW'(1);
                        state_reg <= S_SS;
                    end
                end
                S_FINAL:
                begin
                    if (can_load)
                    begin
                        out_item_reg  <= '{count_reg, held_reg, x_reg, v_reg,
                                           acc_reg, f_reg, 1'b1};
                        held_reg      <= '0;
                        held_flag_reg <= 1'b0;
                        x_reg         <= init_pos_reg;
                        v_reg         <= '0;
                        vb_reg        <= '0;
                        acc_reg       <= '0;
                        f_reg         <= '0;
                        dp_reg        <= '0;
                        stuck_reg     <= 1'b1;
                        count_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_racc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        racc_reg < SUB_DIV)
        else $error("interpolation remainder out of range");
    a_sub_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg <= SUB_LAST)
        else $error("substep counter out of range");
    a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> tbl_ready && !issued_reg)
        else $error("item taken before table fill or with multiply pending");
`endif

endmodule
`default_nettype wire

// ===== tb/valve_stem_friction_sim_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_stem_friction_sim_tb: self-checking bench of the valve stem simulator
// Drives pressure sample sequences under random sender gaps and receiver
// stalls. A bit-true predictor of the stick-slip stem model checks every result.
// ----------------------------------------------------------------------------
module valve_stem_friction_sim_tb;
    import vsf_pkg::*;

    localparam longint QMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QMIN = -QMAX - 1;
    localparam int SETTLE_CYCLES = 1600;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    vsf_in_t  in_item;
    logic     out_valid;
    logic     out_stall;
    vsf_out_t out_item;
    logic     cfg_write;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    valve_stem_friction_sim DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model registers
    longint k_spring, area, preload, f_coulomb, f_static, visc, v_inv, x_init;
    // model state
    longint held_p, pos, vel, vel_prev, acc, fric, p_delay;
    bit has_held, stuck;
    logic [31:0] sample_idx;
    longint unsigned exp_lut[VSF_TABLE_DEPTH];

    vsf_out_t expected_results[$];
    int errors;
    int burst_left;
    int stall_hold;

    always #6 clk = ~clk;

    function automatic longint sat48(longint v);
        return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    // (a*b) >> sh, rounded half away from zero, saturated
    function automatic longint mul_round(longint a, longint b, int sh);
        bit neg;
        logic [127:0] ua, ub, prod;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        prod = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
        if (neg)
            return (prod > 128'h8000_0000_0000) ? QMIN : -longint'(prod);
        return (prod > 128'(QMAX)) ? QMAX : longint'(prod);
    endfunction

    function automatic longint stribeck_decay(longint s);
        longint unsigned idx, frac, hi, nx;
        idx = longint'(s) >> 20;
        frac = s & 64'hF_FFFF;
        if (idx >= VSF_TABLE_DEPTH)
            return 0;
        hi = exp_lut[idx];
        nx = (idx + 1 < VSF_TABLE_DEPTH) ? exp_lut[idx + 1] : 0;
        return longint'(hi - (((hi - nx) * frac) >> 20));
    endfunction

    function automatic void restart_sequence();
        held_p = 0; has_held = 0; pos = x_init; vel = 0; vel_prev = 0;
        acc = 0; fric = 0; p_delay = 0; stuck = 1; sample_idx = 0;
    endfunction

    function automatic void model_reset();
        longint unsigned e;
        e = 64'd1 << 23;
        for (int i = 0; i < VSF_TABLE_DEPTH; i++)
        begin
            exp_lut[i] = e;
            e = (e * 64'(VSF_EXP_R) + (64'd1 << 31)) >> 32;
        end
        k_spring = 0; area = 0; preload = 0; f_coulomb = 0; f_static = 0;
        visc = 0; v_inv = 64'd16777216; x_init = 0;
        restart_sequence();
    endfunction

    function automatic void integrate_substep(longint p_now);
        longint vp, net, fat, a, v, x, mag, lim, u, e, lvl;
        vp = vel;
        if (vel_prev == 0 && !stuck)
            stuck = 0;
        else if (vel_prev == 0 || vp == 0 || ((vel_prev < 0) != (vp < 0)))
            stuck = 1;
        else
            stuck = 0;
        net = sat48(sat48(mul_round(area, p_delay, 24) - mul_round(k_spring, pos, 24))
                    - preload);
        if (stuck)
        begin
            mag = net < 0 ? -net : net;
            lim = mag < f_static ? mag : f_static;
            fat = net < 0 ? -lim : (net > 0 ? lim : 0);
            vp = 0;
            if (lim >= f_static)
                stuck = 0;
        end
        else
        begin
            u = mul_round(vp < 0 ? -vp : vp, v_inv, 24);
            e = stribeck_decay(mul_round(u, u, 24));
            lvl = sat48(f_coulomb + mul_round(f_static - f_coulomb, e, 23));
            fat = vp > 0 ? lvl : (vp < 0 ? sat48(-lvl) : 0);
            fat = sat48(fat + mul_round(visc, vp, 24));
        end
        a = mul_round(sat48(net - fat), longint'(VSF_INV_MASS), 24);
        v = sat48(mul_round(VSF_HALF_DT, sat48(a + acc), 24) + vp);
        x = sat48(mul_round(VSF_HALF_DT, sat48(v + vp), 24) + pos);
        if (x < longint'(VSF_POS_MIN))
        begin
            a = 0; v = 0; x = VSF_POS_MIN; stuck = 1;
        end
        else if (x > longint'(VSF_POS_MAX))
        begin
            a = 0; v = 0; x = VSF_POS_MAX; stuck = 1;
        end
        vel_prev = vp; vel = v; acc = a; pos = x; fric = fat; p_delay = p_now;
    endfunction

    function automatic void push_state(longint pres, bit fin);
        vsf_out_t r;
        r.sample_number = sample_idx;
        r.pressure_value = pres[47:0];
        r.stem_position = pos[47:0];
        r.stem_velocity = vel[47:0];
        r.stem_acceleration = acc[47:0];
        r.friction_force = fric[47:0];
        r.final_result = fin;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_stem(vsf_in_t it);
        longint p;
        p = longint'($signed(it.pressure_sample));
        if (has_held)
        begin
            push_state(held_p, 0);
            for (int c = 0; c < VSF_SUBSTEPS; c++)
                integrate_substep(held_p + ((p - held_p) * c) / longint'(VSF_SUBSTEPS));
            sample_idx++;
        end
        held_p = p;
        has_held = 1;
        if (it.last_sample)
        begin
            push_state(p, 1);
            restart_sequence();
        end
    endfunction

    function automatic void check_field(string name, logic [47:0] e, logic [47:0] a);
        if (e !== a)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
        end
    endfunction

    // compare each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got %h", $time, out_item);
            end
            else
            begin
                vsf_out_t e;
                e = expected_results.pop_front();
                check_field("sample_number", 48'(e.sample_number), 48'(out_item.sample_number));
                check_field("pressure_value", e.pressure_value, out_item.pressure_value);
                check_field("stem_position", e.stem_position, out_item.stem_position);
                check_field("stem_velocity", e.stem_velocity, out_item.stem_velocity);
                check_field("stem_acceleration", e.stem_acceleration,
                            out_item.stem_acceleration);
                check_field("friction_force", e.friction_force, out_item.friction_force);
                check_field("final_result", 48'(e.final_result), 48'(out_item.final_result));
            end
        end
    end

    // receiver: stall pattern of its own, plus long holds on request
    initial
    begin
        int mode, mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                out_stall <= 1;
                stall_hold--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(1, 3000);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] d);
        longint u47, s48;
        u47 = longint'({17'd0, d[46:0]});
        s48 = longint'($signed(d));
        @(negedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_write <= 0;
        case (idx)
            REG_SPRING_STIFFNESS: k_spring = u47;
            REG_DIAPHRAGM_AREA:   area = u47;
            REG_SPRING_PRELOAD:   preload = s48;
            REG_COULOMB_FORCE:    f_coulomb = u47;
            REG_STATIC_FORCE:     f_static = u47;
            REG_VISCOUS_COEFF:    visc = u47;
            REG_STRIBECK_VINV:    v_inv = u47;
            default:              x_init = s48;
        endcase
    endtask

    task automatic send_sample(logic signed [47:0] p, bit last);
        vsf_in_t it;
        it.pressure_sample = p;
        it.last_sample = last;
        @(negedge clk);
        in_valid <= 1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_stem(it);
        // bursts with random gaps; some bursts are long to leave no idling
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40))
            begin
                @(negedge clk);
                in_valid <= 0;
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // settle before the next test writes its configuration
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] pick_reg_value(bit signed_reg);
        case ($urandom_range(0, 9))
            0: return 48'd0;
            1: return signed_reg ? 48'h7FFF_FFFF_FFFF : 48'h7FFF_FFFF_FFFF;
            2: return signed_reg ? 48'h8000_0000_0000 : 48'hFFFF_FFFF_FFFF;
            3: return 48'({$urandom, $urandom});
            4: return signed_reg ? -48'($urandom_range(0, 1 << 26)) : 48'($urandom);
            default: return 48'($urandom_range(0, 1 << 26));
        endcase
    endfunction

    function automatic logic [47:0] pick_pressure();
        case ($urandom_range(0, 11))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'd0;
            3, 4: return 48'({$urandom, $urandom});
            5: return -48'($urandom_range(0, 1 << 26));
            default: return 48'($urandom_range(0, 1 << 27));
        endcase
    endfunction

    task automatic test_directed();
        // defaults: no forces, stem rests
        send_sample(48'd0, 0);
        send_sample(48'h7FFF_FFFF_FFFF, 0);
        send_sample(48'h8000_0000_0000, 0);
        send_sample(48'd0, 1);
        send_sample(48'd16777216, 1);      // lone last sample of a sequence
        wait_idle();
        // moderate plant: breakaway, slip and travel stops
        write_reg(REG_SPRING_STIFFNESS, 48'd16777216);
        write_reg(REG_DIAPHRAGM_AREA, 48'd16777216 * 64);
        write_reg(REG_SPRING_PRELOAD, 48'd1 << 22);
        write_reg(REG_COULOMB_FORCE, 48'd1 << 22);
        write_reg(REG_STATIC_FORCE, 48'd1 << 23);
        write_reg(REG_VISCOUS_COEFF, 48'd1 << 22);
        write_reg(REG_STRIBECK_VINV, 48'd1 << 28);
        write_reg(REG_INITIAL_POSITION, 48'd1 << 23);
        for (int i = 0; i < 8; i++)
            send_sample(48'(i * (1 << 22)), 0);
        send_sample(-48'd16777216, 0);
        send_sample(48'd0, 1);
        wait_idle();
        // every register at its extreme
        write_reg(REG_SPRING_STIFFNESS, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_DIAPHRAGM_AREA, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_SPRING_PRELOAD, 48'h8000_0000_0000);
        write_reg(REG_COULOMB_FORCE, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_STATIC_FORCE, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_VISCOUS_COEFF, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_STRIBECK_VINV, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_INITIAL_POSITION, 48'h8000_0000_0000);
        send_sample(48'h7FFF_FFFF_FFFF, 0);
        send_sample(48'h8000_0000_0000, 0);
        send_sample(48'h7FFF_FFFF_FFFF, 1);
        send_sample(48'h8000_0000_0000, 0);
        send_sample(48'd1, 1);
        wait_idle();
    endtask

    task automatic test_random(int n_items, bit hold_receiver);
        int left;
        write_reg(REG_SPRING_STIFFNESS, pick_reg_value(0));
        write_reg(REG_DIAPHRAGM_AREA, pick_reg_value(0));
        write_reg(REG_SPRING_PRELOAD, pick_reg_value(1));
        write_reg(REG_COULOMB_FORCE, pick_reg_value(0));
        write_reg(REG_STATIC_FORCE, pick_reg_value(0));
        write_reg(REG_VISCOUS_COEFF, pick_reg_value(0));
        write_reg(REG_STRIBECK_VINV, pick_reg_value(0));
        write_reg(REG_INITIAL_POSITION, pick_reg_value(1));
        if (hold_receiver)
            stall_hold = 8000;
        left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (left == 0)
                left = $urandom_range(1, 30);
            left--;
            send_sample(pick_pressure(), left == 0 || i == n_items - 1);
        end
        wait_idle();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        out_stall = 0;
        cfg_write = 0;
        cfg_index = REG_SPRING_STIFFNESS;
        cfg_data = '0;
        errors = 0;
        burst_left = 0;
        stall_hold = 0;
        model_reset();
        repeat (7) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random(280, 1);
        for (int ph = 0; ph < 5; ph++)
            test_random(280, 0);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vsf_pkg.sv
hw/rtl/vsf_front.sv
hw/rtl/vsf_mul.sv
hw/rtl/vsf_stribeck.sv
hw/rtl/vsf_core.sv
hw/rtl/valve_stem_friction_sim.sv
tb/valve_stem_friction_sim_tb.sv
